[rtl/wcca_pkg.sv]
// ----------------------------------------------------------------------------
// Windowed count-change alarm package
// Widths, window depth, register indexes and reset values shared by the block
// and its checker.
// ----------------------------------------------------------------------------
package wcca_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int OCC_W        = $clog2(WINDOW_DEPTH + 1);

  localparam int FRAME_W  = 31;
  localparam int COUNT_W  = 16;
  localparam int CHANGE_W = 17;
  localparam int ENTRY_W  = FRAME_W + COUNT_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_INSIDE_IS_ANOMALY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FRAMES     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_DIRECTION    = 3'd4;

  localparam logic                       RST_INSIDE_IS_ANOMALY = 1'b1;
  localparam logic [FRAME_W-1:0]         RST_WINDOW_FRAMES     = 31'd300;
  localparam logic signed [CHANGE_W-1:0] RST_RANGE_LOW         = 17'sd0;
  localparam logic signed [CHANGE_W-1:0] RST_RANGE_HIGH        = 17'sd5;
  localparam logic                       RST_FLOW_DIRECTION    = 1'b0;

  // Minimum edges from an accepted request to its result showing on the output
  localparam int MIN_LATENCY = 2;

endpackage

[rtl/wcca_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wcca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/windowed_count_change_alarm_unit.sv]
// ----------------------------------------------------------------------------
// Windowed count-change alarm unit
// Keeps a window of (frame, count) entries for one flow and raises an alarm
// when a new count differs from the oldest kept count by an anomalous amount.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one count-change event per
//   request. Output channel (out_valid_o / out_stall_i) carries at most one
//   alarm per event. Config channel (cfg_valid_i / cfg_ready_o) writes the
//   registers by index; writing flow_direction empties the window.
// Sequencing:
//   An event that is ignored (other flow, not a count change, dropped batch)
//   leaves the unit idle. A stored event passes through a read and a compare
//   step, and every entry popped by age adds another read and compare; when
//   the pops empty the window it returns to idle with no result. Each pop
//   re-reads the new head through the registered read port of the window RAM.
//   No new event is taken until the unit is back in idle.
// Reset:
//   Empties the window, clears the drop flag and the output valid flag, and
//   loads the register reset values. The window RAM itself is not cleared.
// Stall:
//   The result waits in an output register; a new event is taken meanwhile.
//   An event that yields a result while the previous one still waits holds in
//   its compare step until the output register frees up.
// ----------------------------------------------------------------------------
module windowed_count_change_alarm_unit (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    first_in_batch_i,
  input  logic                                    batch_is_count_change_i,
  input  logic [wcca_pkg::FRAME_W-1:0]            ref_frame_i,
  input  logic [wcca_pkg::FRAME_W-1:0]            event_frame_i,
  input  logic                                    event_flow_i,
  input  logic [wcca_pkg::COUNT_W-1:0]            running_count_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic                                    alarm_flow_o,
  output logic signed [wcca_pkg::CHANGE_W-1:0]    count_change_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [wcca_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [wcca_pkg::CFG_DATA_W-1:0]         cfg_data_i
);
  import wcca_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC  = OCC_W'(WINDOW_DEPTH);

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    next_idx = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  logic [1:0]                 state_q, state_d;
  logic [IDX_W-1:0]           head_q, head_d, tail_q, tail_d;
  logic [OCC_W-1:0]           occ_q, occ_d;
  logic                       dropped_q, dropped_d;
  logic                       inside_q, inside_d;
  logic [FRAME_W-1:0]         window_q, window_d;
  logic signed [CHANGE_W-1:0] rlow_q, rlow_d, rhigh_q, rhigh_d;
  logic                       dir_q, dir_d;
  logic [FRAME_W-1:0]         ref_q, ref_d;
  logic [COUNT_W-1:0]         cnt_q, cnt_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_flow_q, out_flow_d;
  logic signed [CHANGE_W-1:0] out_change_q, out_change_d;

  logic                       in_acc, cfg_acc, drop_now, ignore;
  logic                       ram_we;
  logic [ENTRY_W-1:0]         ram_wdata, ram_rdata;
  logic [FRAME_W-1:0]         rd_frame;
  logic [COUNT_W-1:0]         rd_count;
  logic signed [FRAME_W:0]    age;
  logic                       evict;
  logic signed [CHANGE_W-1:0] change;
  logic                       in_range, alarm, out_free;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign cfg_ready_o  = (state_q == ST_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign cfg_acc      = cfg_valid_i && cfg_ready_o;
  assign out_valid_o  = out_valid_q;
  assign alarm_flow_o = out_flow_q;
  assign count_change_o = out_change_q;

  assign drop_now  = first_in_batch_i ? 1'b0 : dropped_q;
  assign ignore    = !batch_is_count_change_i || drop_now || (event_flow_i != dir_q);
  assign ram_we    = in_acc && !ignore;
  assign ram_wdata = {event_frame_i, running_count_i};

  assign rd_frame = ram_rdata[ENTRY_W-1:COUNT_W];
  assign rd_count = ram_rdata[COUNT_W-1:0];

  // Age is negative when the reference frame precedes the entry: never evicts
  assign age      = $signed({1'b0, ref_q}) - $signed({1'b0, rd_frame});
  assign evict    = age > $signed({1'b0, window_q});
  assign change   = $signed({1'b0, cnt_q}) - $signed({1'b0, rd_count});
  assign in_range = (change >= rlow_q) && (change <= rhigh_q);
  assign alarm    = inside_q ? in_range : !in_range;
  assign out_free = !out_valid_q || !out_stall_i;

  wcca_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    occ_d        = occ_q;
    dropped_d    = dropped_q;
    inside_d     = inside_q;
    window_d     = window_q;
    rlow_d       = rlow_q;
    rhigh_d      = rhigh_q;
    dir_d        = dir_q;
    ref_d        = ref_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_flow_d   = out_flow_q;
    out_change_d = out_change_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          dropped_d = drop_now;
          if (!ignore) begin
            ref_d  = ref_frame_i;
            cnt_d  = running_count_i;
            tail_d = next_idx(tail_q);
            // Full window: drop the oldest entry to make room
            if (occ_q == FULL_OCC) begin
              head_d = next_idx(head_q);
            end else begin
              occ_d = occ_q + 1'b1;
            end
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (evict) begin
          head_d = next_idx(head_q);
          occ_d  = occ_q - 1'b1;
          if (occ_q == OCC_W'(1)) begin
            dropped_d = 1'b1;
            state_d   = ST_IDLE;
          end else begin
            state_d = ST_READ;
          end
        end else if (!alarm) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_flow_d   = dir_q;
          out_change_d = change;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_acc) begin
      case (cfg_index_i)
        CFG_INSIDE_IS_ANOMALY: inside_d = cfg_data_i[0];
        CFG_WINDOW_FRAMES:     window_d = cfg_data_i[FRAME_W-1:0];
        CFG_RANGE_LOW:         rlow_d   = $signed(cfg_data_i[CHANGE_W-1:0]);
        CFG_RANGE_HIGH:        rhigh_d  = $signed(cfg_data_i[CHANGE_W-1:0]);
        CFG_FLOW_DIRECTION: begin
          dir_d  = cfg_data_i[0];
          head_d = '0;
          tail_d = '0;
          occ_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      dropped_q   <= 1'b0;
      inside_q    <= RST_INSIDE_IS_ANOMALY;
      window_q    <= RST_WINDOW_FRAMES;
      rlow_q      <= RST_RANGE_LOW;
      rhigh_q     <= RST_RANGE_HIGH;
      dir_q       <= RST_FLOW_DIRECTION;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      dropped_q   <= dropped_d;
      inside_q    <= inside_d;
      window_q    <= window_d;
      rlow_q      <= rlow_d;
      rhigh_q     <= rhigh_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ref_q        <= ref_d;
    cnt_q        <= cnt_d;
    out_flow_q   <= out_flow_d;
    out_change_q <= out_change_d;
  end

endmodule

[rtl/wcca_checker.sv]
// ----------------------------------------------------------------------------
// Windowed count-change alarm port checker
// Watches the top-level ports over time and flags handshake and sequencing
// slips.
// ----------------------------------------------------------------------------
module wcca_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic                                 alarm_flow_o,
  input logic signed [wcca_pkg::CHANGE_W-1:0] count_change_o,
  input logic                                 cfg_valid_i,
  input logic                                 cfg_ready_o
);
  import wcca_pkg::*;

  // Hold a stalled result until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(count_change_o) && $stable(alarm_flow_o))
    else $error("stalled result changed");

  // A request never produces its result on the very next edge
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared too early after a request");

  // Configuration is open exactly when the input side is open
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o != in_stall_o)
    else $error("config ready disagrees with input stall");

endmodule

bind windowed_count_change_alarm_unit wcca_checker u_wcca_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .alarm_flow_o   (alarm_flow_o),
  .count_change_o (count_change_o),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_o    (cfg_ready_o)
);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed count-change alarm unit testbench
// Streams count-change events into the unit through a queue-fed driver, keeps
// its own window of (frame, count) entries to predict every alarm, and checks
// the alarm stream field by field under random idle gaps and output stalls.
// Registers are retuned between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb;
  import wcca_pkg::*;

  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 76;
  localparam int DRAIN_CYCLES    = MIN_LATENCY + 2 * WINDOW_DEPTH + 40;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int REPORT_LIMIT    = 10;

  typedef struct {
    logic                first;
    logic                cc;
    logic [FRAME_W-1:0]  ref_frame;
    logic [FRAME_W-1:0]  ev_frame;
    logic                flow;
    logic [COUNT_W-1:0]  count;
  } count_event_t;

  typedef struct {
    logic                       flow;
    logic signed [CHANGE_W-1:0] change;
  } alarm_t;

  logic                   clk_i                   = 1'b0;
  logic                   rst_ni                  = 1'b0;
  logic                   in_valid_i              = 1'b0;
  logic                   in_stall_o;
  logic                   first_in_batch_i        = 1'b0;
  logic                   batch_is_count_change_i = 1'b0;
  logic [FRAME_W-1:0]     ref_frame_i             = '0;
  logic [FRAME_W-1:0]     event_frame_i           = '0;
  logic                   event_flow_i            = 1'b0;
  logic [COUNT_W-1:0]     running_count_i         = '0;
  logic                   out_valid_o;
  logic                   out_stall_i             = 1'b0;
  logic                   alarm_flow_o;
  logic signed [CHANGE_W-1:0] count_change_o;
  logic                   cfg_valid_i             = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i             = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i              = '0;

  windowed_count_change_alarm_unit DUT (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .in_valid_i              (in_valid_i),
    .in_stall_o              (in_stall_o),
    .first_in_batch_i        (first_in_batch_i),
    .batch_is_count_change_i (batch_is_count_change_i),
    .ref_frame_i             (ref_frame_i),
    .event_frame_i           (event_frame_i),
    .event_flow_i            (event_flow_i),
    .running_count_i         (running_count_i),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .alarm_flow_o            (alarm_flow_o),
    .count_change_o          (count_change_o),
    .cfg_valid_i             (cfg_valid_i),
    .cfg_ready_o             (cfg_ready_o),
    .cfg_index_i             (cfg_index_i),
    .cfg_data_i              (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow registers and window
  logic                       m_inside = RST_INSIDE_IS_ANOMALY;
  logic [FRAME_W-1:0]         m_window = RST_WINDOW_FRAMES;
  logic signed [CHANGE_W-1:0] m_lo     = RST_RANGE_LOW;
  logic signed [CHANGE_W-1:0] m_hi     = RST_RANGE_HIGH;
  logic                       m_dir    = RST_FLOW_DIRECTION;
  logic [FRAME_W-1:0]         win_frame [WINDOW_DEPTH];
  logic [COUNT_W-1:0]         win_count [WINDOW_DEPTH];
  int                         win_head  = 0;
  int                         win_tail  = 0;
  int                         win_fill  = 0;
  bit                         drop_rest = 1'b0;

  count_event_t queued_events [$];
  alarm_t       pending_alarms [$];
  count_event_t next_ev;
  count_event_t taken_ev;
  alarm_t       fresh_alarm;
  alarm_t       want;
  bit           event_taken = 1'b0;
  bit           quiet       = 1'b0;
  int           send_gap    = 0;
  int           stall_run   = 0;
  int           free_run    = 0;
  int           fault_count = 0;
  int unsigned  cycle_count = 0;

  // Skip events the unit ignores, append the rest to the window, age out old
  // entries and compare the new count against the oldest one kept.
  function automatic bit predict_alarm(input count_event_t ev, output alarm_t al);
    int change;
    bit hit;
    if (ev.first) drop_rest = 1'b0;
    if (!ev.cc || drop_rest || ev.flow != m_dir) return 1'b0;
    if (win_fill >= WINDOW_DEPTH) begin
      win_head = (win_head + 1) % WINDOW_DEPTH;
      win_fill--;
    end
    win_frame[win_tail] = ev.ev_frame;
    win_count[win_tail] = ev.count;
    win_tail = (win_tail + 1) % WINDOW_DEPTH;
    win_fill++;
    while (win_fill > 0 &&
           longint'(ev.ref_frame) - longint'(win_frame[win_head]) > longint'(m_window)) begin
      win_head = (win_head + 1) % WINDOW_DEPTH;
      win_fill--;
    end
    if (win_fill == 0) begin
      drop_rest = 1'b1;
      return 1'b0;
    end
    change = int'(ev.count) - int'(win_count[win_head]);
    hit = (change >= int'(m_lo)) && (change <= int'(m_hi));
    if (m_inside ? !hit : hit) return 1'b0;
    al.flow   = m_dir;
    al.change = CHANGE_W'(change);
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic add_event(input bit first, input bit cc, input logic [FRAME_W-1:0] rf,
                           input logic [FRAME_W-1:0] ef, input bit flow,
                           input logic [COUNT_W-1:0] cnt);
    count_event_t ev;
    ev = '{first, cc, rf, ef, flow, cnt};
    queued_events.push_back(ev);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for every request and alarm to drain, then let silent events finish.
  task automatic wait_idle();
    while (queued_events.size() != 0 || in_valid_i || pending_alarms.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Request driver: hold each event until it is taken, then idle a while.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || event_taken) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (queued_events.size() != 0) begin
        next_ev = queued_events.pop_front();
        first_in_batch_i        <= next_ev.first;
        batch_is_count_change_i <= next_ev.cc;
        ref_frame_i             <= next_ev.ref_frame;
        event_frame_i           <= next_ev.ev_frame;
        event_flow_i            <= next_ev.flow;
        running_count_i         <= next_ev.count;
        in_valid_i              <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Alarm receiver back-pressure
  always @(negedge clk_i) begin
    if (stall_run > 0) begin
      out_stall_i <= 1'b1;
      stall_run--;
    end else if (free_run > 0) begin
      out_stall_i <= 1'b0;
      free_run--;
    end else begin
      out_stall_i <= 1'b0;
      stall_run = pick_gap();
      free_run  = $urandom_range(1, 10);
    end
  end

  // Monitor: check alarms first, then predict from the request taken at this edge and mirror config writes.
  always @(posedge clk_i) begin
    event_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_alarms.size() == 0) begin
          note_fault($sformatf("unexpected alarm flow %0d change %0d",
                               alarm_flow_o, count_change_o));
        end else begin
          want = pending_alarms.pop_front();
          if (want.flow !== alarm_flow_o || want.change !== count_change_o)
            note_fault($sformatf("expected flow %0d change %0d, got flow %0d change %0d",
                                 want.flow, want.change, alarm_flow_o, count_change_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        taken_ev = '{first_in_batch_i, batch_is_count_change_i, ref_frame_i,
                     event_frame_i, event_flow_i, running_count_i};
        if (predict_alarm(taken_ev, fresh_alarm)) pending_alarms.push_back(fresh_alarm);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_INSIDE_IS_ANOMALY: m_inside = cfg_data_i[0];
          CFG_WINDOW_FRAMES:     m_window = cfg_data_i[FRAME_W-1:0];
          CFG_RANGE_LOW:         m_lo     = cfg_data_i[CHANGE_W-1:0];
          CFG_RANGE_HIGH:        m_hi     = cfg_data_i[CHANGE_W-1:0];
          CFG_FLOW_DIRECTION: begin
            m_dir    = cfg_data_i[0];
            win_head = 0;
            win_tail = 0;
            win_fill = 0;
          end
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    logic signed [CHANGE_W-1:0] lo_v, hi_v;
    logic [FRAME_W-1:0]         gen_frame, ef;
    logic [COUNT_W-1:0]         gen_count;
    int                         lo_i, hi_i, counted, len, r;
    bit                         cc, fl, fb;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed events under reset register values (watch flow 0, window 300, 0..5)
    add_event(1, 1, 31'd100, 31'd100, 0, 16'd10);           // first entry, change zero
    add_event(0, 1, 31'd100, 31'd101, 0, 16'd13);           // small change inside range
    add_event(0, 1, 31'd100, 31'd102, 0, 16'hFFFF);         // large change, no alarm
    add_event(0, 1, 31'd100, 31'd103, 1, 16'd10);           // other flow
    add_event(1, 0, 31'd100, 31'd104, 0, 16'd10);           // not a count-change batch
    add_event(0, 0, 31'd100, 31'd105, 0, 16'd11);
    add_event(1, 1, 31'd500, 31'd450, 0, 16'd15);           // evict three aged entries
    add_event(0, 1, 31'd500, 31'd600, 0, 16'd20);           // event after reference
    add_event(1, 1, 31'h7FFF_FFFF, 31'd0, 0, 16'd0);        // window empties, drop batch
    add_event(0, 1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 16'd1); // dropped
    add_event(1, 1, 31'd0, 31'h7FFF_FFFF, 0, 16'd0);        // new batch ends the drop
    add_event(0, 1, 31'd0, 31'd0, 0, 16'hFFFF);             // largest positive change
    add_event(0, 1, 31'd0, 31'd0, 1, 16'hFFFF);
    add_event(1, 1, 31'd300, 31'd300, 0, 16'd3);            // young head blocks eviction

    gen_frame = FRAME_W'($urandom);
    gen_count = COUNT_W'($urandom);
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      quiet = (p % 4 == 3);
      case (p)
        0, 6: begin
          // never age out: fill the window and wrap over full
          write_reg(CFG_WINDOW_FRAMES, 31'h7FFF_FFFF);
          write_reg(CFG_RANGE_LOW, {14'($urandom), 17'h1_0000});
          write_reg(CFG_RANGE_HIGH, {14'($urandom), 17'h0_FFFF});
          write_reg(CFG_INSIDE_IS_ANOMALY, {30'($urandom), 1'b1});
          write_reg(CFG_FLOW_DIRECTION, {30'($urandom), 1'(p == 0)});
        end
        1: begin
          // full window meets zero age limit: long eviction run
          write_reg(CFG_WINDOW_FRAMES, '0);
          write_reg(CFG_INSIDE_IS_ANOMALY, {30'($urandom), 1'b0});
        end
        default: begin
          write_reg(CFG_WINDOW_FRAMES, ($urandom_range(0, 5) == 0) ? 31'h7FFF_FFFF :
                                       FRAME_W'($urandom_range(0, 400)));
          lo_i = ($urandom_range(0, 5) == 0) ? -65536 : int'($urandom_range(0, 600)) - 300;
          hi_i = ($urandom_range(0, 5) == 0) ? 65535 : lo_i + int'($urandom_range(0, 260)) - 20;
          lo_v = CHANGE_W'(lo_i);
          hi_v = CHANGE_W'(hi_i);
          write_reg(CFG_RANGE_LOW, {14'($urandom), lo_v});
          write_reg(CFG_RANGE_HIGH, {14'($urandom), hi_v});
          write_reg(CFG_INSIDE_IS_ANOMALY, {30'($urandom), 1'($urandom)});
          if ($urandom_range(0, 2) == 0)
            write_reg(CFG_FLOW_DIRECTION, {30'($urandom), 1'($urandom)});
          if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'(CFG_FLOW_DIRECTION + 1 + $urandom_range(0, 2)),
                      CFG_DATA_W'($urandom));
        end
      endcase

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          add_event(1'($urandom), 1'($urandom), FRAME_W'($urandom), FRAME_W'($urandom),
                    1'($urandom), COUNT_W'($urandom));
        end else begin
          len = $urandom_range(1, 6);
          gen_frame += ($urandom_range(0, 19) == 0) ? FRAME_W'($urandom_range(300, 3000)) :
                                                      FRAME_W'($urandom_range(0, 40));
          cc = ($urandom_range(0, 9) != 0);
          for (int k = 0; k < len; k++) begin
            // a batch now and then starts without its first marker
            fb = (k == 0) ? (r >= 12) : ($urandom_range(0, 24) == 0);
            fl = ($urandom_range(0, 4) == 0) ? !m_dir : m_dir;
            ef = ($urandom_range(0, 9) == 0) ? gen_frame + FRAME_W'($urandom_range(1, 50)) :
                                               gen_frame - FRAME_W'($urandom_range(0, 8));
            gen_count = ($urandom_range(0, 49) == 0) ? COUNT_W'($urandom) :
                        gen_count + COUNT_W'($urandom_range(0, 6)) - 16'd2;
            add_event(fb, cc, gen_frame, ef, fl, gen_count);
            if (cc && fl == m_dir) counted++;
          end
        end
      end
    end

    wait_idle();
    if (fault_count == 0 && pending_alarms.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/wcca_pkg.sv
rtl/wcca_ram.sv
rtl/windowed_count_change_alarm_unit.sv
rtl/wcca_checker.sv
dv/tb.sv
